[rtl/core/sacl_pkg.sv]
// ----------------------------------------------------------------------------
// sacl_pkg: shared definitions for the set-associative cache lookup
// Default geometry, stream widths and the command and status groups that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

  localparam int unsigned DefSets       = 8;
  localparam int unsigned DefWays       = 8;
  localparam int unsigned DefOffsetBits = 4;
  localparam int unsigned DefAddrBits   = 32;

  localparam int unsigned AddrW     = 32;
  localparam int unsigned WayOutW   = 3;
  localparam int unsigned CountW    = 32;
  localparam int unsigned OutFieldW = 1 + WayOutW + 2 * CountW;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_READ  = 5'b01000,
    ST_CMP   = 5'b10000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;    // write one cleared row of the tag memory
    logic load;     // capture the incoming address
    logic rd_in;    // read the row of the set taken straight from the input
    logic div_step; // one step of the set/tag division
    logic rd_cur;   // read the row of the set held in the datapath
    logic cmp;      // compare, refill on a miss, update counters and result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic use_div;
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

[rtl/core/sacl_ctrl.sv]
// ----------------------------------------------------------------------------
// sacl_ctrl: sequencer of the cache lookup
// Runs the clearing pass after reset, then steps each item through address
// split, tag row read and compare, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_ctrl
  import sacl_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    s_valid_i,
  output logic         s_ready_o,
  output logic         m_valid_o,
  input  wire logic    m_ready_i,
  input  wire status_t st_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    m_valid_d = m_valid_q & ~m_ready_i;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (st_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          if (st_i.use_div) begin
            state_d = ST_DIV;
          end else begin
            cmd_o.rd_in = 1'b1;
            state_d     = ST_CMP;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (st_i.div_last) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = ST_CMP;
      end
      ST_CMP: begin
        // The result register must be free before the counters move on.
        if (!m_valid_q || m_ready_i) begin
          cmd_o.cmp = 1'b1;
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;

endmodule

`default_nettype wire

[rtl/core/sacl_datapath.sv]
// ----------------------------------------------------------------------------
// sacl_datapath: address split, tag memory, compare and counters
// One memory row per set holds the tags, valid bits and fill pointer of
// that set; a miss writes the modified row back in the compare cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_datapath
  import sacl_pkg::*;
#(
  parameter int unsigned SETS        = DefSets,
  parameter int unsigned WAYS        = DefWays,
  parameter int unsigned OFFSET_BITS = DefOffsetBits,
  parameter int unsigned ADDR_BITS   = DefAddrBits
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output status_t                st_o,
  input  wire logic [AddrW-1:0]  addr_i,
  output logic                   hit_o,
  output logic [WayOutW-1:0]     way_o,
  output logic [CountW-1:0]      hit_count_o,
  output logic [CountW-1:0]      miss_count_o
);

  localparam int unsigned AW        = (ADDR_BITS < AddrW) ? ADDR_BITS : AddrW;
  localparam int unsigned LW        = AW - OFFSET_BITS;
  localparam bit          Pow2      = ((SETS & (SETS - 1)) == 0);
  localparam int unsigned SetLog    = $clog2(SETS);
  localparam int unsigned FloorLog  = Pow2 ? SetLog : SetLog - 1;
  localparam int unsigned TW        = LW - FloorLog;
  localparam int unsigned SetW      = (SETS > 1) ? SetLog : 1;
  localparam int unsigned WayW      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned WayXW     = (WayW > WayOutW) ? WayW : WayOutW;

  typedef struct packed {
    logic [WayW-1:0]            ptr;
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0][TW-1:0]    tags;
  } row_t;

  logic [LW-1:0]   line;
  logic [SetW-1:0] in_set;
  logic [SetW-1:0] cur_set;
  logic [TW-1:0]   cur_tag;

  assign line = addr_i[AW-1:OFFSET_BITS];

  // Set index and tag: plain bit fields for a power-of-two set count,
  // otherwise a multiplication by the rounded-up reciprocal of the set count,
  // split into two partial products and a final sum.
  if (Pow2) begin : g_fields
    logic [SetW-1:0] set_q;
    logic [TW-1:0]   tag_q;

    if (SETS > 1) begin : g_multi
      assign in_set = line[SetW-1:0];
    end else begin : g_single
      assign in_set = '0;
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        set_q <= in_set;
        tag_q <= line[LW-1:FloorLog];
      end
    end

    assign cur_set       = set_q;
    assign cur_tag       = tag_q;
    assign st_o.use_div  = 1'b0;
    assign st_o.div_last = 1'b0;
  end else begin : g_divide
    localparam int unsigned Shift = LW + SetLog;
    localparam int unsigned MW    = LW + 1;
    localparam int unsigned LoW   = MW / 2;
    localparam int unsigned HiW   = MW - LoW;
    localparam int unsigned PW    = LW + MW;
    // Rounded up, this reciprocal gives the exact quotient for every line number.
    localparam logic [63:0]    Recip   = ((64'd1 << Shift) + 64'(SETS) - 64'd1) / 64'(SETS);
    localparam logic [LoW-1:0] RecipLo = Recip[LoW-1:0];
    localparam logic [HiW-1:0] RecipHi = Recip[MW-1:LoW];

    logic [LW-1:0]     line_q;
    logic [LW+LoW-1:0] plo_q;
    logic [LW+HiW-1:0] phi_q;
    logic [LW-1:0]     quo_q;
    logic              step_q;
    logic [PW-1:0]     prod;

    assign prod = PW'(plo_q) + (PW'(phi_q) << LoW);

    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        line_q <= line;
        step_q <= 1'b0;
      end else if (cmd_i.div_step) begin
        if (!step_q) begin
          plo_q <= (LW + LoW)'(line_q) * (LW + LoW)'(RecipLo);
          phi_q <= (LW + HiW)'(line_q) * (LW + HiW)'(RecipHi);
        end else begin
          quo_q <= LW'(prod >> Shift);
        end
        step_q <= ~step_q;
      end
    end

    // The remainder is below SETS, so only its low bits need computing.
    assign in_set        = '0;
    assign cur_set       = SetW'(line_q) - SetW'(SetW'(quo_q) * SetW'(SETS));
    assign cur_tag       = quo_q[TW-1:0];
    assign st_o.use_div  = 1'b1;
    assign st_o.div_last = step_q;
  end

  // Clearing pass over the rows after reset.
  logic [SetW-1:0] clr_q;

  assign st_o.clear_last = (clr_q == SetW'(SETS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear && !st_o.clear_last) begin
      clr_q <= clr_q + SetW'(1);
    end
  end

  // Tag memory.
  row_t            mem [SETS];
  row_t            row_q;
  row_t            new_row;
  logic            rd_en;
  logic [SetW-1:0] rd_addr;
  logic            wr_en;
  logic [SetW-1:0] wr_addr;
  logic [WAYS-1:0] match;
  logic            hit;
  logic [WayW-1:0] hit_way;
  logic [WayW-1:0] ptr_next;

  assign rd_en   = cmd_i.rd_in | cmd_i.rd_cur;
  assign rd_addr = cmd_i.rd_in ? in_set : cur_set;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= new_row;
    end
    if (rd_en) begin
      row_q <= mem[rd_addr];
    end
  end

  always_comb begin
    for (int k = 0; k < WAYS; k++) begin
      match[k] = row_q.valid[k] && (row_q.tags[k] == cur_tag);
    end
    hit     = |match;
    hit_way = '0;
    for (int k = WAYS - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit_way = WayW'(k);
      end
    end
  end

  assign ptr_next = (row_q.ptr == WayW'(WAYS - 1)) ? '0 : row_q.ptr + WayW'(1);

  always_comb begin
    new_row = row_q;
    if (cmd_i.clear) begin
      new_row = '0;
      wr_addr = clr_q;
    end else begin
      new_row.tags[row_q.ptr]  = cur_tag;
      new_row.valid[row_q.ptr] = 1'b1;
      new_row.ptr              = ptr_next;
      wr_addr                  = cur_set;
    end
  end

  assign wr_en = cmd_i.clear | (cmd_i.cmp & ~hit);

  // Result and saturating counters.
  logic [CountW-1:0] hits_q;
  logic [CountW-1:0] misses_q;
  logic              hit_q;
  logic [WayXW-1:0]  way_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
    end else if (cmd_i.cmp) begin
      if (hit) begin
        if (hits_q != '1) begin
          hits_q <= hits_q + CountW'(1);
        end
      end else if (misses_q != '1) begin
        misses_q <= misses_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      hit_q <= hit;
      way_q <= WayXW'(hit ? hit_way : row_q.ptr);
    end
  end

  assign hit_o        = hit_q;
  assign way_o        = way_q[WayOutW-1:0];
  assign hit_count_o  = hits_q;
  assign miss_count_o = misses_q;

endmodule

`default_nettype wire

[rtl/core/set_assoc_fifo_cache_lookup.sv]
// ----------------------------------------------------------------------------
// set_assoc_fifo_cache_lookup: set-associative lookup, FIFO replacement
// Each input item is a byte address. The block reports hit or miss, the way
// that hit or was refilled, and saturating hit and miss totals.
//
// Input channel s_axis: one address per item. Output channel m_axis: one
// result per item. With a power-of-two SETS the accept cycle reads the set's
// row from the tag memory; the compare step then compares, writes the row
// back on a miss and loads the result register. For any other SETS the set
// index and tag come from a multiplication by the reciprocal of SETS in the
// division steps (partial products, then their sum), followed by a separate
// row read step. The single read-modify-write path of the tag memory means
// a new item is accepted only after the last one has passed the compare step.
// After reset a clearing pass over every set empties the valid bits and
// fill pointers; s_axis_tready stays low meanwhile. A new item is accepted
// while a result waits; if the receiver stalls, the next item waits in the
// compare step until the result register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_fifo_cache_lookup
  import sacl_pkg::*;
#(
  parameter int unsigned SETS        = DefSets,
  parameter int unsigned WAYS        = DefWays,
  parameter int unsigned OFFSET_BITS = DefOffsetBits,
  parameter int unsigned ADDR_BITS   = DefAddrBits
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [AddrW-1:0]    s_axis_tdata,   // address[31:0]
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata    // hit, way_used[2:0],
                                                   // hit_count[31:0],
                                                   // miss_count[31:0], zeros
);

  cmd_t                cmd;
  status_t             st;
  logic                hit;
  logic [WayOutW-1:0]  way;
  logic [CountW-1:0]   hit_count;
  logic [CountW-1:0]   miss_count;

  sacl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  sacl_datapath #(
    .SETS        (SETS),
    .WAYS        (WAYS),
    .OFFSET_BITS (OFFSET_BITS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .addr_i       (s_axis_tdata),
    .hit_o        (hit),
    .way_o        (way),
    .hit_count_o  (hit_count),
    .miss_count_o (miss_count)
  );

  assign m_axis_tdata = OutDataW'({miss_count, hit_count, way, hit});

endmodule

`default_nettype wire
